// File: src/acsc_pkg.sv
// Package for the alarm clock seconds counter.
// Digit record type, key and event codes, reset constants. No dependencies.
package acsc_pkg;

    typedef struct packed {
        logic [1:0] ht;
        logic [3:0] ho;
        logic [2:0] mt;
        logic [3:0] mo;
        logic [2:0] st;
        logic [3:0] so;
    } t_hms;

    typedef enum logic [2:0] {
        KEY_NONE = 3'd0,
        KEY_SEC  = 3'd1,
        KEY_MIN  = 3'd2,
        KEY_HOUR = 3'd3,
        KEY_MODE = 3'd4
    } t_key;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_KEY  = 1'b1;

    localparam logic ROW_TIME  = 1'b0;
    localparam logic ROW_ALARM = 1'b1;

    localparam logic [7:0] C_TPS_RESET = 8'd20;

    // digit limits, low digit first
    localparam int C_ONES_MAX  = 9;
    localparam int C_TENS_MAX  = 5;
    localparam int C_HTENS_MAX = 2;
    localparam logic [1:0] C_DAY_HT = 2'd2;
    localparam logic [3:0] C_DAY_HO = 4'd3;

endpackage

// File: src/alarm_clock_seconds_counter_unit.sv
// Top level of the alarm clock seconds counter.
// Uses acsc_pkg and two acsc_chain digit chains (time and alarm).
//
// Usage:
//   Input stream: tuser[0] is the event kind (0 tick, 1 key), tdata[2:0] the
//   key code. Each accepted event updates the prescaler, time, alarm and mode.
//   Output stream: two transfers per event, time row first, alarm row second
//   with tlast high. tuser[0] is the row. tdata carries the HH:MM:SS digits,
//   the ring flag and the alarm-set flag, all taken after the event's update.
//   Config channel: one 8-bit write sets ticks per second; always ready.
// The result is registered: the first row appears the cycle after the event's transfer.
// Throughput: each event gives two output beats; the next event is taken in the
//   cycle the second beat leaves, so the input side never waits on the digit
//   chains.
// Stall: a held result stays on the port; a new event waits only for the
//   last beat of the pending pair.
// Reset: time, alarm, prescaler and mode clear to zero, ticks per second
//   returns to 20, the output is empty. No clearing pass.
module alarm_clock_seconds_counter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [2:0] key_code
    input  logic [0:0]  i_s_axis_tuser,   // [0] func
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [1:0] hour_tens, [5:2] hour_ones,
                                          // [8:6] minute_tens, [12:9] minute_ones,
                                          // [15:13] second_tens, [19:16] second_ones,
                                          // [20] ring, [21] in_setting
    output logic [0:0]  o_m_axis_tuser,   // [0] row
    output logic        o_m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import acsc_pkg::*;

    logic       s_acc;
    logic       m_acc;
    logic       is_tick;
    logic       is_key;
    t_key       key;
    logic [7:0] tick_inc;
    logic       sec_step;
    logic [2:0] time_inc;
    logic [2:0] alarm_inc;
    t_hms       time_next;
    t_hms       alarm_next;
    t_hms       row_sel;
    logic       ring_next;

    logic [7:0] r_tps;
    logic [7:0] r_tick;
    logic [7:0] n_tick;
    logic       r_set_mode;
    logic       n_set_mode;

    logic       r_valid;
    logic       r_phase;
    t_hms       r_time;
    t_hms       r_alarm;
    logic       r_ring;
    logic       r_set;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps <= C_TPS_RESET;
        end else if (i_cfg_valid) begin
            r_tps <= i_cfg_data;
        end
    end

    assign o_s_axis_tready = !r_valid || (r_phase && i_m_axis_tready);
    assign s_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign m_acc   = o_m_axis_tvalid && i_m_axis_tready;
    assign is_tick = s_acc && (i_s_axis_tuser[0] == FUNC_TICK);
    assign is_key  = s_acc && (i_s_axis_tuser[0] == FUNC_KEY);
    assign key     = t_key'(i_s_axis_tdata[2:0]);

    // prescaler
    assign tick_inc = r_tick + 8'd1;
    assign sec_step = is_tick && (tick_inc >= r_tps);

    always_comb begin
        n_tick = r_tick;
        if (is_tick) begin
            n_tick = sec_step ? 8'd0 : tick_inc;
        end
    end

    // key decode
    always_comb begin
        n_set_mode = r_set_mode;
        alarm_inc  = 3'b000;
        if (is_key) begin
            unique case (key)
                KEY_SEC:  alarm_inc[0] = r_set_mode;
                KEY_MIN:  alarm_inc[1] = r_set_mode;
                KEY_HOUR: alarm_inc[2] = r_set_mode;
                KEY_MODE: n_set_mode   = !r_set_mode;
                default:  n_set_mode   = r_set_mode;
            endcase
        end
    end

    assign time_inc = {2'b00, sec_step};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick     <= '0;
            r_set_mode <= 1'b0;
        end else begin
            r_tick     <= n_tick;
            r_set_mode <= n_set_mode;
        end
    end

    acsc_chain u_time (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(time_inc), .o_next(time_next)
    );

    acsc_chain u_alarm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(alarm_inc), .o_next(alarm_next)
    );

    assign ring_next = (time_next == alarm_next) && (alarm_next != '0);

    // output pair buffer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= ROW_TIME;
        end else if (s_acc) begin
            r_valid <= 1'b1;
            r_phase <= ROW_TIME;
        end else if (m_acc) begin
            if (r_phase == ROW_TIME) begin
                r_phase <= ROW_ALARM;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_time  <= time_next;
            r_alarm <= alarm_next;
            r_ring  <= ring_next;
            r_set   <= n_set_mode;
        end
    end

    assign row_sel = (r_phase == ROW_ALARM) ? r_alarm : r_time;

    assign o_m_axis_tvalid   = r_valid;
    assign o_m_axis_tuser[0] = r_phase;
    assign o_m_axis_tlast    = r_phase;
    assign o_m_axis_tdata    = {2'b00, r_set, r_ring, row_sel.so, row_sel.st,
                                row_sel.mo, row_sel.mt, row_sel.ho, row_sel.ht};

    a_ring_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_ring) |-> ((r_time == r_alarm) && (r_alarm != '0)))
        else $error("ring flag without matching nonzero alarm");

    a_mode_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !is_key |=> $stable(r_set_mode))
        else $error("mode changed without a key transfer");

    a_pair_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_acc && (r_phase == ROW_TIME)) |=> (r_valid && (r_phase == ROW_ALARM)))
        else $error("alarm row lost after time row transfer");

endmodule

// File: src/acsc_digit_cell.sv
// One decimal digit cell of an HH:MM:SS chain.
// Counts on i_inc, clears on i_clr, hands a carry to its neighbor; no package dependencies.
module acsc_digit_cell #(
    parameter int W    = 4,
    parameter int MAXV = 9
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_inc,
    input  logic         i_clr,
    output logic         o_carry,
    output logic [W-1:0] o_digit,
    output logic [W-1:0] o_next
);

    logic [W-1:0] r_digit;
    logic [W-1:0] n_digit;
    logic         wrap;

    assign wrap = (r_digit == W'(MAXV));

    always_comb begin
        if (i_clr) begin
            n_digit = '0;
        end else if (i_inc) begin
            n_digit = wrap ? '0 : r_digit + W'(1);
        end else begin
            n_digit = r_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit <= '0;
        end else begin
            r_digit <= n_digit;
        end
    end

    assign o_carry = i_inc & wrap;
    assign o_digit = r_digit;
    assign o_next  = n_digit;

endmodule

// File: src/acsc_chain.sv
// Six digit cells forming a seconds-of-day counter with wrap at 24:00:00.
// Uses acsc_pkg and acsc_digit_cell.
module acsc_chain (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [2:0]    i_inc,     // [0] +1s, [1] +1min, [2] +1h
    output acsc_pkg::t_hms o_next
);
    import acsc_pkg::*;

    logic [5:0] carry;
    logic [5:0] inc;
    logic       clr;
    logic [3:0] cur_ho;
    logic [1:0] cur_ht;

    assign inc[0] = i_inc[0];
    assign inc[1] = carry[0];
    assign inc[2] = i_inc[1] | carry[1];
    assign inc[3] = carry[2];
    assign inc[4] = i_inc[2] | carry[3];
    assign inc[5] = carry[4];

    // 23 -> 24 in the hours is the end of the day
    assign clr = inc[4] && (cur_ht == C_DAY_HT) && (cur_ho == C_DAY_HO);

    acsc_digit_cell #(.W(4), .MAXV(C_ONES_MAX)) u_so (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc[0]), .i_clr(clr),
        .o_carry(carry[0]), .o_digit(), .o_next(o_next.so)
    );
    acsc_digit_cell #(.W(3), .MAXV(C_TENS_MAX)) u_st (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc[1]), .i_clr(clr),
        .o_carry(carry[1]), .o_digit(), .o_next(o_next.st)
    );
    acsc_digit_cell #(.W(4), .MAXV(C_ONES_MAX)) u_mo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc[2]), .i_clr(clr),
        .o_carry(carry[2]), .o_digit(), .o_next(o_next.mo)
    );
    acsc_digit_cell #(.W(3), .MAXV(C_TENS_MAX)) u_mt (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc[3]), .i_clr(clr),
        .o_carry(carry[3]), .o_digit(), .o_next(o_next.mt)
    );
    acsc_digit_cell #(.W(4), .MAXV(C_ONES_MAX)) u_ho (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc[4]), .i_clr(clr),
        .o_carry(carry[4]), .o_digit(cur_ho), .o_next(o_next.ho)
    );
    acsc_digit_cell #(.W(2), .MAXV(C_HTENS_MAX)) u_ht (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inc(inc[5]), .i_clr(clr),
        .o_carry(carry[5]), .o_digit(cur_ht), .o_next(o_next.ht)
    );

endmodule

// File: tb/acsc_display_checker.sv
// Checker for the alarm clock seconds counter: tracks prescaler, time, alarm and mode
// from the input and config transfers and compares every output transfer.
// Depends on acsc_pkg.
module acsc_display_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_valid,
    input  logic        i_s_ready,
    input  logic [7:0]  i_s_data,    // [2:0] key_code
    input  logic [0:0]  i_s_user,    // [0] func
    input  logic        i_m_valid,
    input  logic        i_m_ready,
    input  logic [23:0] i_m_data,    // [1:0] hour_tens, [5:2] hour_ones, [8:6] minute_tens,
                                     // [12:9] minute_ones, [15:13] second_tens,
                                     // [19:16] second_ones, [20] ring, [21] in_setting
    input  logic [0:0]  i_m_user,    // [0] row
    input  logic        i_m_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import acsc_pkg::*;

    localparam int DAY_SEC     = 86400;
    localparam int HOUR_SEC    = 3600;
    localparam int MIN_SEC     = 60;

    typedef struct {
        logic row;
        t_hms hms;
        logic ring;
        logic setting;
        logic last;
    } t_row_exp;

    t_row_exp   expected_rows[$];
    logic [7:0] ticks_per_sec;
    logic [7:0] prescale;
    int         day_sec;
    int         alarm_sec;
    logic       setting;
    int         errors = 0;

    assign o_fail_count = errors;

    function automatic t_hms to_digits(input int s);
        t_hms d;
        d.ht = 2'(s / (10 * HOUR_SEC));
        d.ho = 4'((s / HOUR_SEC) % 10);
        d.mt = 3'((s % HOUR_SEC) / (10 * MIN_SEC));
        d.mo = 4'(((s % HOUR_SEC) / MIN_SEC) % 10);
        d.st = 3'((s % MIN_SEC) / 10);
        d.so = 4'(s % 10);
        return d;
    endfunction

    task automatic advance_clock(input logic func, input logic [2:0] key);
        logic     ring;
        t_row_exp r;
        if (func == FUNC_TICK) begin
            prescale = prescale + 8'd1;
            if (prescale >= ticks_per_sec) begin
                prescale = '0;
                day_sec  = (day_sec + 1 >= DAY_SEC) ? 0 : day_sec + 1;
            end
        end else if (!setting) begin
            if (key == KEY_MODE) setting = 1'b1;
        end else begin
            case (key)
                KEY_SEC:  alarm_sec += 1;
                KEY_MIN:  alarm_sec += MIN_SEC;
                KEY_HOUR: alarm_sec += HOUR_SEC;
                KEY_MODE: setting = 1'b0;
                default: ;
            endcase
            // no modulo: overflow clears the alarm
            if (alarm_sec >= DAY_SEC) alarm_sec = 0;
        end
        ring      = (day_sec == alarm_sec) && (alarm_sec != 0);
        r.row     = ROW_TIME;
        r.hms     = to_digits(day_sec);
        r.ring    = ring;
        r.setting = setting;
        r.last    = 1'b0;
        expected_rows.push_back(r);
        r.row     = ROW_ALARM;
        r.hms     = to_digits(alarm_sec);
        r.last    = 1'b1;
        expected_rows.push_back(r);
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_row_exp want;
        if (!i_rst_n) begin
            ticks_per_sec = C_TPS_RESET;
            prescale      = '0;
            day_sec       = 0;
            alarm_sec     = 0;
            setting       = 1'b0;
            expected_rows.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) ticks_per_sec = i_cfg_data;
            if (i_s_valid && i_s_ready) advance_clock(i_s_user[0], i_s_data[2:0]);
            if (i_m_valid && i_m_ready) begin
                if (expected_rows.size() == 0) begin
                    errors++;
                    $display("%0t: output transfer, expected none, actual row %0d",
                             $time, i_m_user[0]);
                end else begin
                    want = expected_rows.pop_front();
                    compare_field("row",         want.row,     i_m_user[0]);
                    compare_field("hour_tens",   want.hms.ht,  i_m_data[1:0]);
                    compare_field("hour_ones",   want.hms.ho,  i_m_data[5:2]);
                    compare_field("minute_tens", want.hms.mt,  i_m_data[8:6]);
                    compare_field("minute_ones", want.hms.mo,  i_m_data[12:9]);
                    compare_field("second_tens", want.hms.st,  i_m_data[15:13]);
                    compare_field("second_ones", want.hms.so,  i_m_data[19:16]);
                    compare_field("ring",        want.ring,    i_m_data[20]);
                    compare_field("in_setting",  want.setting, i_m_data[21]);
                    compare_field("last",        want.last,    i_m_last);
                end
            end
        end
        o_pending <= expected_rows.size();
    end

endmodule

// File: tb/alarm_clock_seconds_counter_unit_tb.sv
// Testbench top for alarm_clock_seconds_counter_unit: drives events, config writes
// and output backpressure; acsc_display_checker does the checking. Uses acsc_pkg.
module alarm_clock_seconds_counter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import acsc_pkg::*;

    localparam int         RANDOM_ITEMS = 1580;
    localparam int         CYCLE_LIMIT  = 1_000_000;
    localparam int         TAIL_CYCLES  = 8;
    localparam logic [7:0] TPS_ZERO     = 8'd0;
    localparam logic [7:0] TPS_MIN      = 8'd1;
    localparam logic [7:0] TPS_MAX      = 8'd255;
    localparam logic [7:0] TPS_LOWERED  = 8'd2;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data  = '0;

    int fail_count;
    int pending;
    int sent        = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    alarm_clock_seconds_counter_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    acsc_display_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_valid    (s_tvalid),
        .i_s_ready    (s_tready),
        .i_s_data     (s_tdata),
        .i_s_user     (s_tuser),
        .i_m_valid    (m_tvalid),
        .i_m_ready    (m_tready),
        .i_m_data     (m_tdata),
        .i_m_user     (m_tuser),
        .i_m_last     (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_event(input logic func, input logic [2:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, key};
        s_tuser  <= func;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sent++;
    endtask

    // hold off input until every predicted row has been seen
    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_rate(input logic [7:0] rate);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= rate;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] pick_rate;
        if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 6));
    endfunction

    task automatic play_sequence;
        int kind;
        int n;
        int k;
        kind = $urandom_range(0, 9);
        if (kind < 4) begin
            n = $urandom_range(1, 12);
            repeat (n) send_event(FUNC_TICK, 3'($urandom_range(0, 7)));
        end else if (kind < 8) begin
            send_event(FUNC_KEY, KEY_MODE);
            n = $urandom_range(0, 6);
            repeat (n) begin
                k = $urandom_range(0, 9);
                if (k < 5)      send_event(FUNC_KEY, KEY_SEC);
                else if (k < 7) send_event(FUNC_KEY, KEY_MIN);
                else if (k < 8) send_event(FUNC_KEY, KEY_HOUR);
                else if (k < 9) send_event(FUNC_TICK, 3'($urandom_range(0, 7)));
                else            send_event(FUNC_KEY, 3'($urandom_range(0, 7)));
            end
            send_event(FUNC_KEY, KEY_MODE);
        end else begin
            n = $urandom_range(1, 4);
            repeat (n) send_event(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
        end
    endtask

    initial begin
        int k;
        int phase;
        int target;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 17;
        rx_idle_pct = 49;

        // clock mode: key field on a tick, set keys and unused codes do nothing
        send_event(FUNC_TICK, 3'd7);
        send_event(FUNC_KEY, KEY_SEC);
        send_event(FUNC_KEY, KEY_MIN);
        send_event(FUNC_KEY, KEY_HOUR);
        send_event(FUNC_KEY, KEY_NONE);
        for (k = 5; k < 8; k++) send_event(FUNC_KEY, 3'(k));
        // set mode: alarm to 00:00:01, unused codes ignored
        send_event(FUNC_KEY, KEY_MODE);
        send_event(FUNC_KEY, KEY_SEC);
        send_event(FUNC_KEY, KEY_NONE);
        for (k = 5; k < 8; k++) send_event(FUNC_KEY, 3'(k));
        send_event(FUNC_KEY, KEY_MODE);
        // zero rate: every tick is a second; ring at 1 s, cleared at 2 s
        set_rate(TPS_ZERO);
        send_event(FUNC_TICK, KEY_NONE);
        send_event(FUNC_TICK, KEY_NONE);
        send_event(FUNC_KEY, KEY_MODE);
        send_event(FUNC_KEY, KEY_MIN);
        send_event(FUNC_KEY, KEY_HOUR);
        send_event(FUNC_KEY, KEY_MODE);
        // rate lowered below the prescaler count
        set_rate(TPS_MAX);
        repeat (3) send_event(FUNC_TICK, KEY_NONE);
        set_rate(TPS_LOWERED);
        send_event(FUNC_TICK, KEY_NONE);

        // one tick per second, alarm set to 23:59:59 (from 01:01:01)
        set_rate(TPS_MIN);
        repeat (4) send_event(FUNC_TICK, 3'($urandom_range(0, 7)));
        send_event(FUNC_KEY, KEY_MODE);
        repeat (22) send_event(FUNC_KEY, KEY_HOUR);
        repeat (58) send_event(FUNC_KEY, KEY_MIN);
        repeat (58) send_event(FUNC_KEY, KEY_SEC);
        send_event(FUNC_KEY, KEY_MODE);
        // alarm overflow back to zero
        send_event(FUNC_KEY, KEY_MODE);
        send_event(FUNC_KEY, KEY_SEC);
        send_event(FUNC_KEY, KEY_MODE);

        for (phase = 0; phase < 6; phase++) begin
            tx_idle_pct = (phase < 2) ? 17 : (phase < 4) ? 49 : 0;
            rx_idle_pct = (phase < 2) ? 49 : (phase < 4) ? 17 : 0;
            set_rate(pick_rate());
            target = sent + RANDOM_ITEMS / 6;
            while (sent < target) play_sequence();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
src/acsc_pkg.sv
src/acsc_digit_cell.sv
src/acsc_chain.sv
src/alarm_clock_seconds_counter_unit.sv
tb/acsc_display_checker.sv
tb/alarm_clock_seconds_counter_unit_tb.sv
